@@ sv/pgn_pkg.sv @@
package pgn_pkg;

    localparam int COORD_W = 32;
    localparam int NOISE_W = 24;
    localparam int BIAS_W = 9;
    localparam int CEIL_W = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam int FRAC_BITS_DEFAULT = 16;

    // gradient components are the low hash bits
    localparam int GRAD_BITS = 5;
    localparam int GRAD_RANGE = 1 << GRAD_BITS;

    localparam logic [31:0] MIX_A = 32'h8529_7A4D;
    localparam logic [31:0] MIX_B = 32'h68E3_1DA4;
    localparam logic [31:0] MIX_C = 32'h1B56_C4E9;
    localparam logic [31:0] Y_SALT = 32'h251A_B517;

    localparam logic signed [BIAS_W-1:0] BIAS_RESET = 9'sd24;
    localparam logic [CEIL_W-1:0] CEILING_RESET = 8'd128;

    typedef enum logic {
        REG_BIAS    = 1'b0,
        REG_CEILING = 1'b1
    } pgn_reg_t;

    // per-stage advance enables for the hash pipeline
    typedef struct packed {
        logic hash_mul;
        logic hash_mix;
        logic hash_out;
    } pgn_step_t;

endpackage

@@ sv/pgn_mangle.sv @@
module pgn_mangle (
    input  logic                               clk,
    input  pgn_pkg::pgn_step_t                 step,
    input  logic [31:0]                        value,
    output logic [pgn_pkg::GRAD_BITS-1:0]      grad
);

    logic [31:0] mul_reg;
    logic [31:0] mix_reg;
    logic [pgn_pkg::GRAD_BITS-1:0] grad_reg;

    logic [31:0] mul_next;
    logic [31:0] fold_a;
    logic [31:0] fold_b;
    logic [31:0] fold_c;
    logic [31:0] mix_next;
    logic [31:0] fold_d;
    logic [pgn_pkg::GRAD_BITS-1:0] grad_next;

    assign mul_next = value * pgn_pkg::MIX_A;
    assign fold_a = mul_reg ^ (mul_reg >> 8);
    assign fold_b = fold_a + pgn_pkg::MIX_B;
    assign fold_c = fold_b ^ (fold_b << 8);
    assign mix_next = fold_c * pgn_pkg::MIX_C;
    assign fold_d = mix_reg ^ (mix_reg >> 8);
    assign grad_next = fold_d[pgn_pkg::GRAD_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (step.hash_mul)
        begin
            mul_reg <= mul_next;
        end
        if (step.hash_mix)
        begin
            mix_reg <= mix_next;
        end
        if (step.hash_out)
        begin
            grad_reg <= grad_next;
        end
    end

    assign grad = grad_reg;

endmodule

@@ sv/perlin_gradient_noise_2d_core.sv @@
// 2d gradient noise core
//
// sample channel: x_coord and y_coord, signed fixed point with FRAC_BITS
// fraction bits, taken on sample_valid and sample_ready. noise channel:
// noise_value, unsigned fixed point with FRAC_BITS fraction bits, offered on
// noise_valid until noise_ready completes the transfer.
// bias and ceiling are written over the apb port at byte addresses 0 and 4;
// pready is tied high and reads return the stored value.
//
// the datapath is nine register stages: lattice split, hash multiplies,
// smoothstep, corner dot products, two lerps and the bias/clamp stage. one
// sample is taken every cycle while sample_ready is high; the depth is set
// by the two dependent 32-bit multiplies of each hash plus the salt
// multiply ahead of the y hashes.
// a stalled receiver holds the output stage; earlier stages keep moving into
// empty slots, so sample_ready drops only once every stage holds a sample.
// reset empties the pipeline and sets bias to 24 and ceiling to 128.
module perlin_gradient_noise_2d_core #(
    parameter int FRAC_BITS = pgn_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pgn_pkg::CFG_ADDR_W-1:0]        paddr,
    input  logic [pgn_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic [pgn_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                  pready,

    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic signed [pgn_pkg::COORD_W-1:0]    x_coord,
    input  logic signed [pgn_pkg::COORD_W-1:0]    y_coord,

    output logic                                  noise_valid,
    input  logic                                  noise_ready,
    output logic [pgn_pkg::NOISE_W-1:0]           noise_value
);

    localparam int GB = pgn_pkg::GRAD_BITS;
    localparam int NS = 9;
    localparam int TW = FRAC_BITS + 2;
    localparam int WW = FRAC_BITS + 1;
    localparam int PW = GB + FRAC_BITS + 2;
    localparam int DW = GB + FRAC_BITS + 3;
    localparam int PDW = DW + WW + 2;
    localparam int CW = FRAC_BITS + pgn_pkg::CEIL_W;
    localparam int VW = DW + 10;

    function automatic logic signed [DW-1:0] dot(
        input logic [GB-1:0]              gx,
        input logic [GB-1:0]              gy,
        input logic signed [FRAC_BITS:0]  dx,
        input logic signed [FRAC_BITS:0]  dy
    );
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        px = PW'($signed({1'b0, gx})) * PW'(dx);
        py = PW'($signed({1'b0, gy})) * PW'(dy);
        return DW'(px) + DW'(py);
    endfunction

    // configuration
    logic signed [pgn_pkg::BIAS_W-1:0] bias_reg;
    logic [pgn_pkg::CEIL_W-1:0]        ceiling_reg;
    logic                              cfg_write;
    pgn_pkg::pgn_reg_t                 cfg_sel;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel = pgn_pkg::pgn_reg_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_sel)
            pgn_pkg::REG_BIAS:
                prdata = {{(pgn_pkg::CFG_DATA_W - pgn_pkg::BIAS_W){1'b0}}, bias_reg};
            pgn_pkg::REG_CEILING:
                prdata = {{(pgn_pkg::CFG_DATA_W - pgn_pkg::CEIL_W){1'b0}}, ceiling_reg};
            default:
                prdata = '0;
        endcase
    end

    // pipeline control
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] stage_adv;
    pgn_pkg::pgn_step_t hash_step;

    always_comb
    begin
        stage_adv[NS-1] = !vld_reg[NS-1] || noise_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            stage_adv[k] = !vld_reg[k] || stage_adv[k+1];
        end
    end

    always_comb
    begin
        vld_next[0] = stage_adv[0] ? sample_valid : vld_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            vld_next[k] = stage_adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign sample_ready = stage_adv[0];
    assign noise_valid = vld_reg[NS-1];

    assign hash_step = '{hash_mul: stage_adv[1], hash_mix: stage_adv[2],
                         hash_out: stage_adv[3]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            bias_reg <= pgn_pkg::BIAS_RESET;
            ceiling_reg <= pgn_pkg::CEILING_RESET;
        end
        else
        begin
            vld_reg <= vld_next;
            if (cfg_write)
            begin
                unique case (cfg_sel)
                    pgn_pkg::REG_BIAS:
                        bias_reg <= $signed(pwdata[pgn_pkg::BIAS_W-1:0]);
                    pgn_pkg::REG_CEILING:
                        ceiling_reg <= pwdata[pgn_pkg::CEIL_W-1:0];
                    default:
                        ;
                endcase
            end
        end
    end

    // stage a: lattice split and y salt
    logic [31:0] cx0_next;
    logic [31:0] cy0_next;
    logic [31:0] cx1_next;
    logic [31:0] cy1_next;

    assign cx0_next = x_coord >>> FRAC_BITS;
    assign cy0_next = y_coord >>> FRAC_BITS;
    assign cx1_next = cx0_next + 32'd1;
    assign cy1_next = cy0_next + 32'd1;

    logic [31:0]              a_cx0_reg;
    logic [31:0]              a_cx1_reg;
    logic [31:0]              a_sy0_reg;
    logic [31:0]              a_sy1_reg;
    logic [FRAC_BITS-1:0]     a_fx_reg;
    logic [FRAC_BITS-1:0]     a_fy_reg;
    logic [2*FRAC_BITS-1:0]   a_fxx_reg;
    logic [2*FRAC_BITS-1:0]   a_fyy_reg;

    always_ff @(posedge clk)
    begin
        if (stage_adv[0])
        begin
            a_cx0_reg <= cx0_next;
            a_cx1_reg <= cx1_next;
            a_sy0_reg <= cy0_next * pgn_pkg::Y_SALT;
            a_sy1_reg <= cy1_next * pgn_pkg::Y_SALT;
            a_fx_reg <= x_coord[FRAC_BITS-1:0];
            a_fy_reg <= y_coord[FRAC_BITS-1:0];
            a_fxx_reg <= (2*FRAC_BITS)'(x_coord[FRAC_BITS-1:0])
                         * (2*FRAC_BITS)'(x_coord[FRAC_BITS-1:0]);
            a_fyy_reg <= (2*FRAC_BITS)'(y_coord[FRAC_BITS-1:0])
                         * (2*FRAC_BITS)'(y_coord[FRAC_BITS-1:0]);
        end
    end

    // stages b to d: corner hashes
    logic [GB-1:0] gx0;
    logic [GB-1:0] gx1;
    logic [GB-1:0] gy0;
    logic [GB-1:0] gy1;

    pgn_mangle u_hash_x0 (.clk(clk), .step(hash_step), .value(a_cx0_reg), .grad(gx0));
    pgn_mangle u_hash_x1 (.clk(clk), .step(hash_step), .value(a_cx1_reg), .grad(gx1));
    pgn_mangle u_hash_y0 (.clk(clk), .step(hash_step), .value(a_sy0_reg), .grad(gy0));
    pgn_mangle u_hash_y1 (.clk(clk), .step(hash_step), .value(a_sy1_reg), .grad(gy1));

    // stage b: smoothstep product
    logic [TW-1:0] tx_next;
    logic [TW-1:0] ty_next;

    assign tx_next = (TW'(3) << FRAC_BITS) - {1'b0, a_fx_reg, 1'b0};
    assign ty_next = (TW'(3) << FRAC_BITS) - {1'b0, a_fy_reg, 1'b0};

    logic [FRAC_BITS-1:0]     b_fx_reg;
    logic [FRAC_BITS-1:0]     b_fy_reg;
    logic [2*FRAC_BITS+1:0]   b_stx_reg;
    logic [2*FRAC_BITS+1:0]   b_sty_reg;

    always_ff @(posedge clk)
    begin
        if (stage_adv[1])
        begin
            b_fx_reg <= a_fx_reg;
            b_fy_reg <= a_fy_reg;
            b_stx_reg <= (2*FRAC_BITS+2)'(a_fxx_reg[2*FRAC_BITS-1:FRAC_BITS])
                         * (2*FRAC_BITS+2)'(tx_next);
            b_sty_reg <= (2*FRAC_BITS+2)'(a_fyy_reg[2*FRAC_BITS-1:FRAC_BITS])
                         * (2*FRAC_BITS+2)'(ty_next);
        end
    end

    // stage c: weights
    logic [FRAC_BITS-1:0] c_fx_reg;
    logic [FRAC_BITS-1:0] c_fy_reg;
    logic [WW-1:0]        c_wx_reg;
    logic [WW-1:0]        c_wy_reg;

    always_ff @(posedge clk)
    begin
        if (stage_adv[2])
        begin
            c_fx_reg <= b_fx_reg;
            c_fy_reg <= b_fy_reg;
            c_wx_reg <= b_stx_reg[2*FRAC_BITS:FRAC_BITS];
            c_wy_reg <= b_sty_reg[2*FRAC_BITS:FRAC_BITS];
        end
    end

    // stage d: carry alongside the hash outputs
    logic [FRAC_BITS-1:0] d_fx_reg;
    logic [FRAC_BITS-1:0] d_fy_reg;
    logic [WW-1:0]        d_wx_reg;
    logic [WW-1:0]        d_wy_reg;

    always_ff @(posedge clk)
    begin
        if (stage_adv[3])
        begin
            d_fx_reg <= c_fx_reg;
            d_fy_reg <= c_fy_reg;
            d_wx_reg <= c_wx_reg;
            d_wy_reg <= c_wy_reg;
        end
    end

    // stage e: corner dot products, far offsets are f - 1
    logic signed [FRAC_BITS:0] dx0;
    logic signed [FRAC_BITS:0] dx1;
    logic signed [FRAC_BITS:0] dy0;
    logic signed [FRAC_BITS:0] dy1;

    assign dx0 = $signed({1'b0, d_fx_reg});
    assign dx1 = $signed({1'b1, d_fx_reg});
    assign dy0 = $signed({1'b0, d_fy_reg});
    assign dy1 = $signed({1'b1, d_fy_reg});

    logic signed [DW-1:0] e_d00_reg;
    logic signed [DW-1:0] e_d10_reg;
    logic signed [DW-1:0] e_d01_reg;
    logic signed [DW-1:0] e_d11_reg;
    logic [WW-1:0]        e_wx_reg;
    logic [WW-1:0]        e_wy_reg;

    always_ff @(posedge clk)
    begin
        if (stage_adv[4])
        begin
            e_d00_reg <= dot(gx0, gy0, dx0, dy0);
            e_d10_reg <= dot(gx1, gy0, dx1, dy0);
            e_d01_reg <= dot(gx0, gy1, dx0, dy1);
            e_d11_reg <= dot(gx1, gy1, dx1, dy1);
            e_wx_reg <= d_wx_reg;
            e_wy_reg <= d_wy_reg;
        end
    end

    // stage f: x lerp products
    logic signed [DW:0]    diff0_next;
    logic signed [DW:0]    diff1_next;
    logic signed [PDW-1:0] p0_next;
    logic signed [PDW-1:0] p1_next;

    assign diff0_next = (DW+1)'(e_d10_reg) - (DW+1)'(e_d00_reg);
    assign diff1_next = (DW+1)'(e_d11_reg) - (DW+1)'(e_d01_reg);
    assign p0_next = PDW'(diff0_next) * PDW'($signed({1'b0, e_wx_reg}));
    assign p1_next = PDW'(diff1_next) * PDW'($signed({1'b0, e_wx_reg}));

    logic signed [DW-1:0]  f_a0_reg;
    logic signed [DW-1:0]  f_a1_reg;
    logic signed [PDW-1:0] f_p0_reg;
    logic signed [PDW-1:0] f_p1_reg;
    logic [WW-1:0]         f_wy_reg;

    always_ff @(posedge clk)
    begin
        if (stage_adv[5])
        begin
            f_a0_reg <= e_d00_reg;
            f_a1_reg <= e_d01_reg;
            f_p0_reg <= p0_next;
            f_p1_reg <= p1_next;
            f_wy_reg <= e_wy_reg;
        end
    end

    // stage g: x lerp sums, floor by arithmetic shift
    logic signed [PDW-1:0] sh0;
    logic signed [PDW-1:0] sh1;

    assign sh0 = f_p0_reg >>> FRAC_BITS;
    assign sh1 = f_p1_reg >>> FRAC_BITS;

    logic signed [DW-1:0] g_l0_reg;
    logic signed [DW-1:0] g_l1_reg;
    logic [WW-1:0]        g_wy_reg;

    always_ff @(posedge clk)
    begin
        if (stage_adv[6])
        begin
            g_l0_reg <= f_a0_reg + DW'(sh0);
            g_l1_reg <= f_a1_reg + DW'(sh1);
            g_wy_reg <= f_wy_reg;
        end
    end

    // stage h: y lerp product
    logic signed [DW:0]    diff2_next;
    logic signed [PDW-1:0] q_next;

    assign diff2_next = (DW+1)'(g_l1_reg) - (DW+1)'(g_l0_reg);
    assign q_next = PDW'(diff2_next) * PDW'($signed({1'b0, g_wy_reg}));

    logic signed [DW-1:0]  h_l0_reg;
    logic signed [PDW-1:0] h_q_reg;

    always_ff @(posedge clk)
    begin
        if (stage_adv[7])
        begin
            h_l0_reg <= g_l0_reg;
            h_q_reg <= q_next;
        end
    end

    // stage i: y lerp sum, bias and clamp
    logic signed [PDW-1:0] h_sh;
    logic signed [VW-1:0]  bias_sh;
    logic signed [VW-1:0]  v_next;
    logic [CW-1:0]         hi;
    logic signed [VW-1:0]  hi_s;
    logic [CW-1:0]         clamp_next;
    logic [pgn_pkg::NOISE_W-1:0] noise_reg;

    assign h_sh = h_q_reg >>> FRAC_BITS;
    assign bias_sh = VW'(bias_reg) <<< FRAC_BITS;
    assign v_next = VW'(h_l0_reg) + VW'(h_sh) + bias_sh;
    assign hi = {ceiling_reg, {FRAC_BITS{1'b0}}};
    assign hi_s = $signed({{(VW - CW){1'b0}}, hi});

    always_comb
    begin
        if (v_next < 0)
        begin
            clamp_next = '0;
        end
        else if (v_next > hi_s)
        begin
            clamp_next = hi;
        end
        else
        begin
            clamp_next = v_next[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv[8])
        begin
            noise_reg <= pgn_pkg::NOISE_W'(clamp_next);
        end
    end

    assign noise_value = noise_reg;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAC = pgn_pkg::FRAC_BITS_DEFAULT;
    localparam int PIPE_DEPTH = 9;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEMS_PER_PHASE = 86;
    localparam int REPORT_LIMIT = 10;

    // zero noise at a lattice point, so only the reset bias of 24 remains
    localparam logic [pgn_pkg::NOISE_W-1:0] LATTICE_NOISE = 24'h18_0000;

    typedef struct packed {
        logic [pgn_pkg::COORD_W-1:0] x;
        logic [pgn_pkg::COORD_W-1:0] y;
        logic                        fixed;
        logic [pgn_pkg::NOISE_W-1:0] noise;
    } sample_row_t;

    localparam int N_ROWS = 14;
    localparam sample_row_t DIRECTED [N_ROWS] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, LATTICE_NOISE},
        '{32'h7FFF_0000, 32'h8000_0000, 1'b1, LATTICE_NOISE},
        '{32'hFFFF_0000, 32'hFFFF_0000, 1'b1, LATTICE_NOISE},
        '{32'h8000_0000, 32'h7FFF_0000, 1'b1, LATTICE_NOISE},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
        '{32'h8000_0001, 32'hFFFF_FFFF, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{32'hFFFF_8000, 32'h0000_8000, 1'b0, '0},
        '{32'h0000_FFFF, 32'h0000_0001, 1'b0, '0},
        '{32'h0001_0000, 32'hFFFF_FFFF, 1'b0, '0},
        '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, '0},
        '{32'hFFFE_4000, 32'h0003_C000, 1'b0, '0},
        '{32'h0000_8000, 32'h0000_8000, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0}
    };

    localparam int N_FIXED_PHASES = 6;
    localparam int PHASE_BIAS [N_FIXED_PHASES] = '{-256, 255, -128, 128, 0, -1};
    localparam int PHASE_CEIL [N_FIXED_PHASES] = '{255, 255, 0, 255, 1, 128};
    localparam int N_PHASES = N_FIXED_PHASES + 2;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [pgn_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [pgn_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [pgn_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    logic                               sample_valid = 1'b0;
    logic                               sample_ready;
    logic signed [pgn_pkg::COORD_W-1:0] x_coord = '0;
    logic signed [pgn_pkg::COORD_W-1:0] y_coord = '0;

    logic                        noise_valid;
    logic                        noise_ready = 1'b0;
    logic [pgn_pkg::NOISE_W-1:0] noise_value;

    logic signed [pgn_pkg::BIAS_W-1:0] cur_bias = pgn_pkg::BIAS_RESET;
    logic [pgn_pkg::CEIL_W-1:0]        cur_ceiling = pgn_pkg::CEILING_RESET;

    logic [pgn_pkg::NOISE_W-1:0] noise_due [$];
    logic [pgn_pkg::NOISE_W-1:0] due_value;
    int mismatch_count = 0;
    int cycle_count = 0;
    int stall_left = 0;
    logic steady = 1'b0;

    perlin_gradient_noise_2d_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .noise_valid  (noise_valid),
        .noise_ready  (noise_ready),
        .noise_value  (noise_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] hash32(input logic [31:0] v);
        logic [31:0] h;
        h = v * pgn_pkg::MIX_A;
        h = h ^ (h >> 8);
        h = h + pgn_pkg::MIX_B;
        h = h ^ (h << 8);
        h = h * pgn_pkg::MIX_C;
        h = h ^ (h >> 8);
        return h;
    endfunction

    function automatic longint fade(input longint f);
        longint s;
        longint t;
        s = (f * f) >>> FRAC;
        t = (longint'(3) <<< FRAC) - 2 * f;
        return (s * t) >>> FRAC;
    endfunction

    function automatic longint corner_dot(input logic [31:0] cx, input logic [31:0] cy,
                                          input longint dx, input longint dy);
        logic [31:0] hx;
        logic [31:0] hy;
        longint gx;
        longint gy;
        hx = hash32(cx);
        hy = hash32(32'(pgn_pkg::Y_SALT * cy));
        gx = longint'(hx[pgn_pkg::GRAD_BITS-1:0]);
        gy = longint'(hy[pgn_pkg::GRAD_BITS-1:0]);
        return gx * dx + gy * dy;
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint w);
        return a + (((b - a) * w) >>> FRAC);
    endfunction

    function automatic logic [pgn_pkg::NOISE_W-1:0] noise_at(
        input logic signed [pgn_pkg::COORD_W-1:0] xin,
        input logic signed [pgn_pkg::COORD_W-1:0] yin);
        longint x;
        longint y;
        longint fx;
        longint fy;
        longint ix;
        longint iy;
        longint one;
        longint wx;
        longint wy;
        longint top;
        longint bot;
        longint v;
        longint hi;
        logic [31:0] cx0;
        logic [31:0] cy0;
        logic [31:0] cx1;
        logic [31:0] cy1;
        x = longint'(xin);
        y = longint'(yin);
        one = longint'(1) <<< FRAC;
        ix = x >>> FRAC;
        iy = y >>> FRAC;
        fx = longint'(xin[FRAC-1:0]);
        fy = longint'(yin[FRAC-1:0]);
        cx0 = ix[31:0];
        cy0 = iy[31:0];
        cx1 = cx0 + 32'd1;
        cy1 = cy0 + 32'd1;
        wx = fade(fx);
        wy = fade(fy);
        top = blend(corner_dot(cx0, cy0, fx, fy), corner_dot(cx1, cy0, fx - one, fy), wx);
        bot = blend(corner_dot(cx0, cy1, fx, fy - one),
                    corner_dot(cx1, cy1, fx - one, fy - one), wx);
        v = blend(top, bot, wy) + longint'(cur_bias) * one;
        hi = longint'(cur_ceiling) <<< FRAC;
        if (v < 0)
            v = 0;
        if (v > hi)
            v = hi;
        return v[pgn_pkg::NOISE_W-1:0];
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [pgn_pkg::COORD_W-1:0] pick_coord();
        logic [pgn_pkg::COORD_W-1:0] c;
        int r;
        c = $urandom();
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2, 3: c[31:16] = 16'(int'($urandom_range(0, 15)) - 8);
            6: c[31:16] = 16'hFFFF;
            7:
            begin
                case ($urandom_range(0, 3))
                    0: c[15:0] = 16'h0000;
                    1: c[15:0] = 16'hFFFF;
                    2: c[15:0] = 16'h0001;
                    default: c[15:0] = 16'h8000;
                endcase
            end
            8: c[31:16] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: ;
        endcase
        return c;
    endfunction

    task automatic apb_write(input pgn_pkg::pgn_reg_t which,
                             input logic [pgn_pkg::CFG_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= pgn_pkg::CFG_ADDR_W'({which, 2'b00});
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (which == pgn_pkg::REG_BIAS)
            cur_bias = data[pgn_pkg::BIAS_W-1:0];
        else
            cur_ceiling = data[pgn_pkg::CEIL_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drive_sample(input logic [pgn_pkg::COORD_W-1:0] x,
                                input logic [pgn_pkg::COORD_W-1:0] y,
                                input logic fixed,
                                input logic [pgn_pkg::NOISE_W-1:0] fixed_noise);
        int gap;
        gap = steady ? 0 : rand_gap();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        x_coord <= x;
        y_coord <= y;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        if (fixed)
            noise_due.push_back(fixed_noise);
        else
            noise_due.push_back(noise_at(x, y));
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (noise_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    // result checking and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n && noise_valid && noise_ready)
        begin
            if (noise_due.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("%0t: noise transfer %h with nothing expected", $time, noise_value);
                mismatch_count++;
            end
            else
            begin
                due_value = noise_due.pop_front();
                if (noise_value !== due_value)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: noise_value expected %h got %h",
                                 $time, due_value, noise_value);
                    mismatch_count++;
                end
            end
        end
        if (steady)
            noise_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            noise_ready <= 1'b0;
        end
        else
        begin
            stall_left = rand_gap();
            if (stall_left == 0)
                noise_ready <= 1'b1;
            else
            begin
                noise_ready <= 1'b0;
                stall_left--;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        int bias_val;
        int ceil_val;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
            drive_sample(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].fixed, DIRECTED[i].noise);
        drain();

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p < N_FIXED_PHASES)
            begin
                bias_val = PHASE_BIAS[p];
                ceil_val = PHASE_CEIL[p];
            end
            else
            begin
                bias_val = $urandom_range(0, 511);
                ceil_val = $urandom_range(0, 255);
            end
            apb_write(pgn_pkg::REG_BIAS, pgn_pkg::CFG_DATA_W'(bias_val) & 32'h1FF);
            apb_write(pgn_pkg::REG_CEILING, pgn_pkg::CFG_DATA_W'(ceil_val) & 32'hFF);
            // one phase runs with no random gaps on either side
            steady <= (p == 3);
            @(posedge clk);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // sender holds off until the pipeline has emptied
                if (n == 40 && (p == 1 || $urandom_range(0, 2) == 0))
                    drain();
                drive_sample(pick_coord(), pick_coord(), 1'b0, '0);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

@@ perlin_gradient_noise_2d_core.f @@
sv/pgn_pkg.sv
sv/pgn_mangle.sv
sv/perlin_gradient_noise_2d_core.sv
tb/tb_top.sv
